// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define FFRA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define FFRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Types, constants and helpers of the first-fit region allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffra_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int STEP_SHIFT  = 18;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LINK_W      = $clog2(TABLE_DEPTH + 1);
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(TABLE_DEPTH);
    localparam logic [32:0] STEP_MASK = 33'((64'd1 << STEP_SHIFT) - 64'd1);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_ZERO      = 3'd4;

    typedef struct packed {
        logic [31:0]       start;
        logic [31:0]       length;
        logic [31:0]       handed;
        logic              is_free;
        logic              in_use;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             we_start;
        logic             we_len;
        logic             we_handed;
        logic             we_free;
        logic             we_use;
        logic             we_next;
        logic             we_prev;
        entry_t           data;
    } wr_t;

    typedef struct packed {
        logic        go;
        logic [31:0] base;
        logic [31:0] length;
    } init_t;

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_SPLIT_SPARE, S_SPLIT_CUR, S_SPLIT_NEXT, S_TAKE,
        S_FREE_MARK, S_PREV_READ, S_PM_KEEP, S_PM_NX, S_PM_GONE,
        S_NEXT_READ, S_NM_KEEP, S_NM_NX, S_NM_GONE, S_DONE
    } state_t;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < NIL_LINK;
    endfunction

endpackage

// ===== rtl/ffra_cell.sv =====
// ----------------------------------------------------------------------------
// ffra_cell
// One table entry with its links; passes the spare-entry search to its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffra_cell import ffra_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  init_t            init,
    input  wr_t              wr,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data,
    input  logic             spare_in,
    output logic             spare_out,
    output logic             spare_hit
);

    entry_t ent_reg;
    logic   is_head;

    assign is_head = (cell_idx == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.start   <= '0;
            ent_reg.length  <= '0;
            ent_reg.handed  <= '0;
            ent_reg.is_free <= is_head;
            ent_reg.in_use  <= is_head;
            ent_reg.nxt     <= NIL_LINK;
            ent_reg.prv     <= NIL_LINK;
        end else if (init.go) begin
            if (is_head) begin
                ent_reg.start  <= init.base;
                ent_reg.length <= init.length;
                ent_reg.handed <= init.base;
            end
            ent_reg.is_free <= is_head;
            ent_reg.in_use  <= is_head;
            ent_reg.nxt     <= NIL_LINK;
            ent_reg.prv     <= NIL_LINK;
        end else if (wr.en && wr.idx == cell_idx) begin
            if (wr.we_start)  ent_reg.start   <= wr.data.start;
            if (wr.we_len)    ent_reg.length  <= wr.data.length;
            if (wr.we_handed) ent_reg.handed  <= wr.data.handed;
            if (wr.we_free)   ent_reg.is_free <= wr.data.is_free;
            if (wr.we_use)    ent_reg.in_use  <= wr.data.in_use;
            if (wr.we_next)   ent_reg.nxt     <= wr.data.nxt;
            if (wr.we_prev)   ent_reg.prv     <= wr.data.prv;
        end
    end

    assign rd_data   = (rd_idx == cell_idx) ? ent_reg : '0;
    // first unused entry wins: an earlier cell that is unused blocks this one
    assign spare_hit = !spare_in && !ent_reg.in_use;
    assign spare_out = spare_in || !ent_reg.in_use;

endmodule

// ===== rtl/ffra_seq.sv =====
// ----------------------------------------------------------------------------
// ffra_seq
// Request sequencer: walks the chain, splits on allocate, merges on free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffra_seq import ffra_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic [31:0]      s_phys_address,
    input  logic [31:0]      s_byte_count,
    input  logic [31:0]      s_release_address,
    output logic [IDX_W-1:0] rd_idx,
    input  entry_t           rd_data,
    input  logic             spare_found,
    input  logic [IDX_W-1:0] spare_idx,
    output wr_t              wr,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_mapped
);

    state_t                state_reg, state_next;
    logic                  kind_reg;
    logic [STEP_SHIFT-1:0] off_reg;
    logic [32:0]           need_reg;
    logic [31:0]           addr_reg;
    logic [LINK_W-1:0]     cur_reg;
    logic [LINK_W-1:0]     steps_reg;
    logic [IDX_W-1:0]      spare_reg;
    entry_t                ent_reg;
    entry_t                q_reg;
    logic [2:0]            status_reg;
    logic [31:0]           mapped_reg;
    logic                  m_valid_reg;
    logic [2:0]            m_status_reg;
    logic [31:0]           m_mapped_reg;

    logic        accept;
    logic        walk_end;
    logic        walk_hit;
    logic [32:0] sum_w;
    logic [32:0] need_w;
    logic        done_load;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign sum_w     = {1'b0, s_byte_count} + 33'(s_phys_address[STEP_SHIFT-1:0]);
    assign need_w    = (sum_w + STEP_MASK) & ~STEP_MASK;
    assign walk_end  = !link_ok(cur_reg) || (steps_reg >= NIL_LINK);
    assign walk_hit  = kind_reg ? (!rd_data.is_free && rd_data.handed == addr_reg)
                                : (rd_data.is_free && {1'b0, rd_data.length} >= need_reg);
    assign done_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        rd_idx     = cur_reg[IDX_W-1:0];
        wr         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!s_req_type && s_byte_count == '0) state_next = S_DONE;
                    else state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    state_next = S_DONE;
                end else if (walk_hit) begin
                    if (kind_reg) state_next = S_FREE_MARK;
                    else if ({1'b0, rd_data.length} > need_reg)
                        state_next = spare_found ? S_SPLIT_SPARE : S_DONE;
                    else state_next = S_TAKE;
                end
            end
            S_SPLIT_SPARE: begin
                wr.en           = 1'b1;
                wr.idx          = spare_reg;
                wr.we_start     = 1'b1;
                wr.we_len       = 1'b1;
                wr.we_handed    = 1'b1;
                wr.we_free      = 1'b1;
                wr.we_use       = 1'b1;
                wr.we_next      = 1'b1;
                wr.we_prev      = 1'b1;
                wr.data.start   = ent_reg.start + need_reg[31:0];
                wr.data.length  = ent_reg.length - need_reg[31:0];
                wr.data.handed  = ent_reg.start + need_reg[31:0];
                wr.data.is_free = 1'b1;
                wr.data.in_use  = 1'b1;
                wr.data.nxt     = ent_reg.nxt;
                wr.data.prv     = cur_reg;
                state_next      = S_SPLIT_CUR;
            end
            S_SPLIT_CUR: begin
                wr.en          = 1'b1;
                wr.idx         = cur_reg[IDX_W-1:0];
                wr.we_len      = 1'b1;
                wr.we_next     = 1'b1;
                wr.we_free     = 1'b1;
                wr.we_handed   = 1'b1;
                wr.data.length = need_reg[31:0];
                wr.data.nxt    = LINK_W'(spare_reg);
                wr.data.handed = ent_reg.start + 32'(off_reg);
                state_next     = link_ok(ent_reg.nxt) ? S_SPLIT_NEXT : S_DONE;
            end
            S_SPLIT_NEXT: begin
                wr.en       = 1'b1;
                wr.idx      = ent_reg.nxt[IDX_W-1:0];
                wr.we_prev  = 1'b1;
                wr.data.prv = LINK_W'(spare_reg);
                state_next  = S_DONE;
            end
            S_TAKE: begin
                wr.en          = 1'b1;
                wr.idx         = cur_reg[IDX_W-1:0];
                wr.we_free     = 1'b1;
                wr.we_handed   = 1'b1;
                wr.data.handed = ent_reg.start + 32'(off_reg);
                state_next     = S_DONE;
            end
            S_FREE_MARK: begin
                wr.en           = 1'b1;
                wr.idx          = cur_reg[IDX_W-1:0];
                wr.we_free      = 1'b1;
                wr.data.is_free = 1'b1;
                if (link_ok(ent_reg.prv)) state_next = S_PREV_READ;
                else if (link_ok(ent_reg.nxt)) state_next = S_NEXT_READ;
                else state_next = S_DONE;
            end
            S_PREV_READ: begin
                rd_idx = ent_reg.prv[IDX_W-1:0];
                if (rd_data.is_free) begin
                    // merge stops where the neighbor does not touch this region
                    if (rd_data.start + rd_data.length != ent_reg.start) state_next = S_DONE;
                    else state_next = S_PM_KEEP;
                end else begin
                    state_next = link_ok(ent_reg.nxt) ? S_NEXT_READ : S_DONE;
                end
            end
            S_PM_KEEP: begin
                wr.en          = 1'b1;
                wr.idx         = ent_reg.prv[IDX_W-1:0];
                wr.we_len      = 1'b1;
                wr.we_next     = 1'b1;
                wr.data.length = q_reg.length + ent_reg.length;
                wr.data.nxt    = ent_reg.nxt;
                state_next     = link_ok(ent_reg.nxt) ? S_PM_NX : S_PM_GONE;
            end
            S_PM_NX: begin
                wr.en       = 1'b1;
                wr.idx      = ent_reg.nxt[IDX_W-1:0];
                wr.we_prev  = 1'b1;
                wr.data.prv = ent_reg.prv;
                state_next  = S_PM_GONE;
            end
            S_PM_GONE: begin
                wr.en       = 1'b1;
                wr.idx      = cur_reg[IDX_W-1:0];
                wr.we_free  = 1'b1;
                wr.we_use   = 1'b1;
                wr.we_next  = 1'b1;
                wr.we_prev  = 1'b1;
                wr.data.nxt = NIL_LINK;
                wr.data.prv = NIL_LINK;
                state_next  = link_ok(ent_reg.nxt) ? S_NEXT_READ : S_DONE;
            end
            S_NEXT_READ: begin
                rd_idx = ent_reg.nxt[IDX_W-1:0];
                if (rd_data.is_free && ent_reg.start + ent_reg.length == rd_data.start)
                    state_next = S_NM_KEEP;
                else state_next = S_DONE;
            end
            S_NM_KEEP: begin
                wr.en          = 1'b1;
                wr.idx         = cur_reg[IDX_W-1:0];
                wr.we_len      = 1'b1;
                wr.we_next     = 1'b1;
                wr.data.length = ent_reg.length + q_reg.length;
                wr.data.nxt    = q_reg.nxt;
                state_next     = link_ok(q_reg.nxt) ? S_NM_NX : S_NM_GONE;
            end
            S_NM_NX: begin
                wr.en       = 1'b1;
                wr.idx      = q_reg.nxt[IDX_W-1:0];
                wr.we_prev  = 1'b1;
                wr.data.prv = cur_reg;
                state_next  = S_NM_GONE;
            end
            S_NM_GONE: begin
                wr.en       = 1'b1;
                wr.idx      = ent_reg.nxt[IDX_W-1:0];
                wr.we_free  = 1'b1;
                wr.we_use   = 1'b1;
                wr.we_next  = 1'b1;
                wr.we_prev  = 1'b1;
                wr.data.nxt = NIL_LINK;
                wr.data.prv = NIL_LINK;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (done_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    // request context and working copies of the entries in play
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_reg   <= s_req_type;
                    off_reg    <= s_phys_address[STEP_SHIFT-1:0];
                    need_reg   <= need_w;
                    addr_reg   <= s_release_address;
                    cur_reg    <= '0;
                    steps_reg  <= '0;
                    mapped_reg <= '0;
                    status_reg <= ST_ZERO;
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    status_reg <= kind_reg ? ST_NOT_FOUND : ST_NO_FIT;
                end else if (walk_hit) begin
                    ent_reg    <= rd_data;
                    spare_reg  <= spare_idx;
                    status_reg <= (!kind_reg && {1'b0, rd_data.length} > need_reg
                                   && !spare_found) ? ST_FULL : ST_OK;
                end else begin
                    cur_reg   <= rd_data.nxt;
                    steps_reg <= steps_reg + 1'b1;
                end
            end
            S_SPLIT_CUR, S_TAKE: mapped_reg <= ent_reg.start + 32'(off_reg);
            S_PREV_READ, S_NEXT_READ: q_reg <= rd_data;
            S_PM_GONE: begin
                // the kept neighbor becomes the current region
                cur_reg        <= ent_reg.prv;
                ent_reg.start  <= q_reg.start;
                ent_reg.length <= q_reg.length + ent_reg.length;
                ent_reg.prv    <= q_reg.prv;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_load) begin
            m_status_reg <= status_reg;
            m_mapped_reg <= mapped_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_mapped = m_mapped_reg;

endmodule

// ===== rtl/first_fit_region_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit allocator over one address window, with split and coalescing.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser: req_type; tdata: phys_address, byte_count,
//           |           | release_address
//  m_*      | out       | tdata: status, mapped_address
//  cfg_*    | in        | index 0 window_base, 1 window_length
//
//  One request at a time. Allocate: accept, walk, then up to three writes
//  (spare entry, current entry, next entry; or one write to take a region),
//  where the walk visits one chained entry per cycle (at most TABLE_DEPTH
//  entries); a zero-size request skips the walk. Free: accept, walk, mark,
//  then read and merge the previous and next neighbors. The table has one
//  write port into the row of entry cells. Reset and any config write
//  rebuild the table. A stalled result is held in the output register while
//  the block already takes the next request; that request waits only at its end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_region_allocator_core import ffra_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // [0] req_type
    input  logic [95:0]  s_tdata,   // [31:0] phys_address, [63:32] byte_count,
                                    // [95:64] release_address
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // [2:0] status, [34:3] mapped_address, rest zero
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [31:0] base_reg;
    logic [31:0] length_reg;
    init_t       init;

    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;
    entry_t           cell_rd [TABLE_DEPTH];
    logic             chain   [TABLE_DEPTH+1];
    logic             hit     [TABLE_DEPTH];
    logic             spare_found;
    logic [IDX_W-1:0] spare_idx;
    wr_t              wr;
    logic [2:0]       status;
    logic [31:0]      mapped;

    // config is always taken; either register rebuilds the table
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            length_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index) length_reg <= cfg_data;
            else base_reg <= cfg_data;
        end
    end

    assign init.go     = cfg_valid;
    assign init.base   = cfg_index ? base_reg : cfg_data;
    assign init.length = cfg_index ? cfg_data : length_reg;

    // row of entry cells; the spare search ripples from cell 0 upward
    assign chain[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        ffra_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (IDX_W'(i)),
            .init      (init),
            .wr        (wr),
            .rd_idx    (rd_idx),
            .rd_data   (cell_rd[i]),
            .spare_in  (chain[i]),
            .spare_out (chain[i+1]),
            .spare_hit (hit[i])
        );
    end

    // only the addressed cell drives its entry, so OR the row together
    always_comb begin
        rd_data   = '0;
        spare_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            rd_data   = rd_data | cell_rd[i];
            spare_idx = spare_idx | (hit[i] ? IDX_W'(i) : '0);
        end
    end

    assign spare_found = chain[TABLE_DEPTH];

    ffra_seq u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_tvalid),
        .s_ready           (s_tready),
        .s_req_type        (s_tuser),
        .s_phys_address    (s_tdata[31:0]),
        .s_byte_count      (s_tdata[63:32]),
        .s_release_address (s_tdata[95:64]),
        .rd_idx            (rd_idx),
        .rd_data           (rd_data),
        .spare_found       (spare_found),
        .spare_idx         (spare_idx),
        .wr                (wr),
        .m_valid           (m_tvalid),
        .m_ready           (m_tready),
        .m_status          (status),
        .m_mapped          (mapped)
    );

    assign m_tdata = {5'b0, mapped, status};

endmodule

// ===== rtl/ffra_checker.sv =====
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `FFRA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FFRA_ASSERT_NOW(a_status_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd4)
    `FFRA_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_tvalid && m_tdata[2:0] != 3'd0, m_tdata[34:3] == 32'd0)
    `FFRA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit region allocator core: a local model
// of the region table predicts status and mapped address for each request,
// and every result item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ffra_pkg::*;

    localparam int TD = TABLE_DEPTH;
    localparam logic [4:0] NIL = 5'(TD);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] mapped;
    } alloc_reply_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic         s_tuser = 1'b0;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_data = '0;

    // Model state of the region table.
    logic [31:0] win_base, win_len;
    logic [31:0] r_start [TD];
    logic [31:0] r_len [TD];
    logic [31:0] r_handed [TD];
    logic        r_free [TD];
    logic        r_used [TD];
    logic [4:0]  r_next [TD];
    logic [4:0]  r_prev [TD];

    alloc_reply_t pending_replies[$];
    logic [31:0]  live_addrs[$];
    int           errors = 0;
    int           sent = 0;
    int           checked = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    // Drive the clock: 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    first_fit_region_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Rebuild the table as one free region covering the window.
    function automatic void table_init();
        for (int i = 0; i < TD; i++) begin
            r_start[i] = '0; r_len[i] = '0; r_handed[i] = '0;
            r_free[i] = 1'b0; r_used[i] = 1'b0; r_next[i] = NIL; r_prev[i] = NIL;
        end
        r_start[0] = win_base; r_len[0] = win_len; r_handed[0] = win_base;
        r_free[0] = 1'b1; r_used[0] = 1'b1;
    endfunction

    function automatic alloc_reply_t predict_alloc(logic [31:0] phys, logic [31:0] count);
        alloc_reply_t r;
        logic [31:0] ofs;
        logic [32:0] need;
        logic [4:0]  cur, spare, nx;
        int          steps;
        bit          found;
        r = '0;
        found = 0;
        steps = 0;
        cur = 0;
        spare = NIL;
        ofs = phys & ((32'd1 << STEP_SHIFT) - 1);
        if (count == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        need = {1'b0, count} + ofs;
        need = (need + STEP_MASK) & ~STEP_MASK;
        while (cur < NIL && steps < TD) begin
            if (r_free[cur] && {1'b0, r_len[cur]} >= need) begin
                found = 1;
                break;
            end
            cur = r_next[cur];
            steps++;
        end
        if (!found) begin
            r.status = ST_NO_FIT;
            return r;
        end
        if ({1'b0, r_len[cur]} > need) begin
            for (int i = TD - 1; i >= 0; i--)
                if (!r_used[i]) spare = 5'(i);
            if (spare == NIL) begin
                r.status = ST_FULL;
                return r;
            end
            r_used[spare] = 1'b1;
            r_start[spare] = r_start[cur] + need[31:0];
            r_len[spare] = r_len[cur] - need[31:0];
            r_handed[spare] = r_start[spare];
            r_free[spare] = 1'b1;
            r_len[cur] = need[31:0];
            nx = r_next[cur];
            r_prev[spare] = cur;
            r_next[spare] = nx;
            r_next[cur] = spare;
            if (nx < NIL) r_prev[nx] = spare;
        end
        r_free[cur] = 1'b0;
        r_handed[cur] = r_start[cur] + ofs;
        r.status = ST_OK;
        r.mapped = r_handed[cur];
        return r;
    endfunction

    // Absorb entry gone into entry keep and retire gone.
    function automatic void merge_into(logic [4:0] keep, logic [4:0] gone);
        logic [4:0] nx;
        nx = r_next[gone];
        r_len[keep] = r_len[keep] + r_len[gone];
        r_next[keep] = nx;
        if (nx < NIL) r_prev[nx] = keep;
        r_used[gone] = 1'b0; r_free[gone] = 1'b0;
        r_next[gone] = NIL; r_prev[gone] = NIL;
    endfunction

    function automatic logic [2:0] predict_free(logic [31:0] addr);
        logic [4:0] cur, q;
        int         steps;
        bit         found;
        cur = 0;
        steps = 0;
        found = 0;
        while (cur < NIL && steps < TD) begin
            if (!r_free[cur] && r_handed[cur] == addr) begin
                found = 1;
                break;
            end
            cur = r_next[cur];
            steps++;
        end
        if (!found) return ST_NOT_FOUND;
        r_free[cur] = 1'b1;
        q = r_prev[cur];
        if (q < NIL && r_free[q]) begin
            if (r_start[q] + r_len[q] != r_start[cur]) return ST_OK;
            merge_into(q, cur);
            cur = q;
        end
        q = r_next[cur];
        if (q < NIL && r_free[q]) begin
            if (r_start[cur] + r_len[cur] != r_start[q]) return ST_OK;
            merge_into(cur, q);
        end
        return ST_OK;
    endfunction

    // Write one register; the block must be idle.
    task automatic write_window(logic idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == 1'b0) win_base = value; else win_len = value;
        table_init();
        live_addrs.delete();
        @(posedge aclk);
    endtask

    // Send one request item and queue its prediction at acceptance.
    task automatic send_request(logic kind, logic [31:0] phys, logic [31:0] count,
                                logic [31:0] rel);
        alloc_reply_t r;
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {rel, count, phys};
        do @(posedge aclk); while (!s_tready);
        if (kind == 1'b0) begin
            r = predict_alloc(phys, count);
            if (r.status == ST_OK) live_addrs.push_back(r.mapped);
        end else begin
            r = '0;
            r.status = predict_free(rel);
            if (r.status == ST_OK)
                foreach (live_addrs[i]) if (live_addrs[i] == rel) begin
                    live_addrs.delete(i);
                    break;
                end
        end
        pending_replies.push_back(r);
        sent++;
        s_tvalid <= 1'b0;
        // the block is busy after taking an item
        @(posedge aclk);
    endtask

    // Hold until every predicted result has arrived, then let the block settle.
    task automatic drain();
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Receiver: random stall and compare each result item.
    always @(posedge aclk) begin
        alloc_reply_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_replies.pop_front();
                    checked++;
                    if (m_tdata[2:0] !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[34:3] !== want.mapped) begin
                        $display("%0t: mapped_address expected %h actual %h",
                                 $time, want.mapped, m_tdata[34:3]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] rand_count();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(3);
            default: return $urandom_range(32'h0010_0000, 1);
        endcase
    endfunction

    // Pick a release address: mostly a live one, sometimes a wrong one.
    function automatic logic [31:0] pick_release();
        if (live_addrs.size() != 0 && $urandom_range(9) < 8)
            return live_addrs[$urandom_range(live_addrs.size() - 1)];
        return $urandom;
    endfunction

    task automatic test_directed();
        write_window(1'b0, 32'h1000_0000);
        write_window(1'b1, 32'h0100_0000);
        send_request(1'b0, 32'h0000_0000, 32'h0, 0);          // zero size
        send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);  // oversized
        send_request(1'b0, 32'h0003_FFFF, 32'h1, 0);          // offset at top of step
        send_request(1'b0, 32'h1234_5678, 32'h0004_0000, 0);
        send_request(1'b0, 32'h0, 32'h00E0_0000, 0);
        send_request(1'b1, 0, 0, 32'hDEAD_BEEF);              // not found
        send_request(1'b1, 0, 0, 32'h1000_0000 + 32'h3FFFF);
        send_request(1'b1, 0, 0, pick_release());
        send_request(1'b1, 0, 0, pick_release());
        // Exhaust the table with small allocations to reach table full.
        for (int i = 0; i < 18; i++) send_request(1'b0, $urandom, 32'h100, 0);
        drain();
        // Window wrapping past the top of the address space.
        write_window(1'b0, 32'hFFF0_0000);
        write_window(1'b1, 32'h0080_0000);
        send_request(1'b0, 32'hFFFF_FFFF, 32'h0020_0000, 0);
        send_request(1'b0, 32'h0, 32'h0010_0000, 0);
        send_request(1'b1, 0, 0, pick_release());
        send_request(1'b1, 0, 0, pick_release());
        drain();
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0)
                send_request(1'b0, $urandom, rand_count(), $urandom);
            else
                send_request(1'b1, $urandom, $urandom, pick_release());
        end
        drain();
    endtask

    task automatic test_random();
        logic [31:0] lens[5];
        lens = '{32'h0, 32'hFFFF_FFFF, 32'h0200_0000, 32'h0080_0000, 32'h0004_0000};
        for (int p = 0; p < 5; p++) begin
            write_window(1'b0, $urandom & ~32'h3FFFF);
            write_window(1'b1, lens[p]);
            case (p % 4)
                0: random_phase(380, 0, 0);
                1: random_phase(380, 61, 0);
                2: random_phase(380, 0, 61);
                default: random_phase(380, 10, 10);
            endcase
        end
        write_window(1'b0, 32'hFFFF_FFFF);
        write_window(1'b1, 32'h0);
        random_phase(20, 10, 10);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        win_base = 0;
        win_len = 0;
        table_init();
        test_directed();
        test_random();
        $display("Covered %0d requests, %0d results checked, over several windows", sent,
                 checked);
        $display("and idle phases including zero-size, oversized, full and unknown frees.");
        if (errors == 0 && pending_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
